### rtl/core/h1_regularization_pixel_update_defines.svh
// Assertion macros shared by the pixel update RTL.
`ifndef H1_REGULARIZATION_PIXEL_UPDATE_DEFINES_SVH
`define H1_REGULARIZATION_PIXEL_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define H1RPU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define H1RPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/h1rpu_pkg.sv
// Shared types and constants of the H1 pixel update block.
package h1rpu_pkg;

   // field widths
   localparam int COORD_W  = 9;
   localparam int PIX_W    = 20;
   localparam int STEP_W   = 16;
   localparam int SIZE_W   = 10;
   localparam int DIM_W    = 13;
   localparam int ACTION_W = 2;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // smallest usable image side
   localparam int MIN_DIM = 3;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

   // register index codes (byte address bits [3:2])
   localparam logic [1:0] REG_FIDELITY  = 2'd0;
   localparam logic [1:0] REG_SMOOTHING = 2'd1;
   localparam logic [1:0] REG_WIDTH     = 2'd2;
   localparam logic [1:0] REG_HEIGHT    = 2'd3;

   // register reset values
   localparam logic [STEP_W-1:0] FIDELITY_RST  = 16'd655;
   localparam logic [STEP_W-1:0] SMOOTHING_RST = 16'd3277;
   localparam logic [SIZE_W-1:0] WIDTH_RST     = 10'd512;
   localparam logic [SIZE_W-1:0] HEIGHT_RST    = 10'd512;

   typedef struct packed {
      logic [STEP_W-1:0] fidelity_step;
      logic [STEP_W-1:0] smoothing_step;
      logic [SIZE_W-1:0] image_width;
      logic [SIZE_W-1:0] image_height;
   } cfg_type;

   // one-hot phase strobes for the stencil arithmetic
   typedef struct packed {
      logic load_center;
      logic add_pair;
      logic add_last;
      logic mult;
   } math_ctl_type;

endpackage

### rtl/core/h1rpu_csr.sv
// Configuration register file with an APB-style access port.
module h1rpu_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [h1rpu_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [h1rpu_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [h1rpu_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready,
   output h1rpu_pkg::cfg_type            cfg
);

   h1rpu_pkg::cfg_type cfg_ff;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fidelity_step  <= h1rpu_pkg::FIDELITY_RST;
         cfg_ff.smoothing_step <= h1rpu_pkg::SMOOTHING_RST;
         cfg_ff.image_width    <= h1rpu_pkg::WIDTH_RST;
         cfg_ff.image_height   <= h1rpu_pkg::HEIGHT_RST;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            h1rpu_pkg::REG_FIDELITY:
               cfg_ff.fidelity_step <= csr_pwdata[h1rpu_pkg::STEP_W-1:0];
            h1rpu_pkg::REG_SMOOTHING:
               cfg_ff.smoothing_step <= csr_pwdata[h1rpu_pkg::STEP_W-1:0];
            h1rpu_pkg::REG_WIDTH:
               cfg_ff.image_width <= csr_pwdata[h1rpu_pkg::SIZE_W-1:0];
            h1rpu_pkg::REG_HEIGHT:
               cfg_ff.image_height <= csr_pwdata[h1rpu_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (csr_paddr[3:2])
         h1rpu_pkg::REG_FIDELITY:  csr_prdata = h1rpu_pkg::CSR_DW'(cfg_ff.fidelity_step);
         h1rpu_pkg::REG_SMOOTHING: csr_prdata = h1rpu_pkg::CSR_DW'(cfg_ff.smoothing_step);
         h1rpu_pkg::REG_WIDTH:     csr_prdata = h1rpu_pkg::CSR_DW'(cfg_ff.image_width);
         h1rpu_pkg::REG_HEIGHT:    csr_prdata = h1rpu_pkg::CSR_DW'(cfg_ff.image_height);
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/h1rpu_math.sv
// Stencil arithmetic: Laplacian accumulate, step products, rounding, saturation.
module h1rpu_math (
   input  logic                                  clock,
   input  h1rpu_pkg::math_ctl_type               ctl,
   input  logic [h1rpu_pkg::STEP_W-1:0]          fidelity_step,
   input  logic [h1rpu_pkg::STEP_W-1:0]          smoothing_step,
   input  logic signed [h1rpu_pkg::PIX_W-1:0]    port_a,
   input  logic signed [h1rpu_pkg::PIX_W-1:0]    port_b,
   input  logic signed [h1rpu_pkg::PIX_W-1:0]    observed,
   output logic signed [h1rpu_pkg::PIX_W-1:0]    step_result
);

   localparam int DIFF_W = h1rpu_pkg::PIX_W + 1;
   localparam int LAP_W  = h1rpu_pkg::PIX_W + 3;
   localparam int FPR_W  = DIFF_W + h1rpu_pkg::STEP_W + 1;
   localparam int LPR_W  = LAP_W + h1rpu_pkg::STEP_W + 1;
   localparam int SUM_W  = LPR_W + 1;
   localparam int RND_W  = SUM_W - 16;
   localparam int NEW_W  = RND_W + 1;

   localparam logic signed [LPR_W-1:0] ROUND_HALF = LPR_W'(32768);
   localparam logic signed [NEW_W-1:0] PIX_HI     = NEW_W'(524287);
   localparam logic signed [NEW_W-1:0] PIX_LO     = -NEW_W'(524288);

   logic signed [h1rpu_pkg::PIX_W-1:0] u_ff;
   logic signed [DIFF_W-1:0]           diff_ff;
   logic signed [LAP_W-1:0]            acc_ff;
   logic signed [FPR_W-1:0]            fid_prod_ff;
   logic signed [LPR_W-1:0]            fid_bias_ff;
   logic signed [LPR_W-1:0]            lap_prod_ff;
   logic signed [SUM_W-1:0]            sum;
   logic signed [RND_W-1:0]            rounded;
   logic signed [NEW_W-1:0]            updated;

   // accumulate the stencil as the reads come back, then multiply
   always_ff @(posedge clock) begin
      if (ctl.load_center) begin
         u_ff    <= port_a;
         diff_ff <= DIFF_W'(observed) - DIFF_W'(port_a);
         acc_ff  <= LAP_W'(port_b) - (LAP_W'(port_a) <<< 2);
      end
      if (ctl.add_pair) begin
         acc_ff <= acc_ff + LAP_W'(port_a) + LAP_W'(port_b);
      end
      if (ctl.add_last) begin
         acc_ff      <= acc_ff + LAP_W'(port_a);
         fid_prod_ff <= FPR_W'($signed({1'b0, fidelity_step})) * FPR_W'(diff_ff);
      end
      if (ctl.mult) begin
         lap_prod_ff <= LPR_W'($signed({1'b0, smoothing_step})) * LPR_W'(acc_ff);
         fid_bias_ff <= LPR_W'(fid_prod_ff) + ROUND_HALF;
      end
   end

   // Q.24 sum, half already added: floor to Q.8, add to pixel, saturate
   always_comb begin
      sum     = SUM_W'(lap_prod_ff) + SUM_W'(fid_bias_ff);
      rounded = $signed(sum[SUM_W-1:16]);
      updated = NEW_W'(u_ff) + NEW_W'(rounded);
      if (updated > PIX_HI)      step_result = PIX_HI[h1rpu_pkg::PIX_W-1:0];
      else if (updated < PIX_LO) step_result = PIX_LO[h1rpu_pkg::PIX_W-1:0];
      else                       step_result = updated[h1rpu_pkg::PIX_W-1:0];
   end

endmodule

### rtl/core/h1_regularization_pixel_update.sv
// Top level: image memories, item sequencer and result register.
//
//   channel   dir   handshake               payload
//   req_*     in    tvalid/tready           tuser: action; tdata: col, row, pixel_in
//   rsp_*     out   tvalid/tready           tdata: col_out, row_out, pixel_out
//   csr_*     in    psel/penable/pready     one 32-bit register write or read
//
// One item at a time. Load and out-of-image items go straight to write-back,
// read and border copy items take one read slot first, and an interior update
// shares its five neighbor reads over the two read ports of the estimate memory
// (three read slots); the Laplacian sum, the two step products and the rounded write-back follow in turn.
// Reset is synchronous: it clears the sequencer and the result valid flag and
// restores the register reset values; the memory contents stay undefined until written.
// A full result register that is not taken holds the write-back step until
// rsp_tready; a new item is taken as soon as the last one is written back.
module h1_regularization_pixel_update #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   // item input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,   // col[8:0], row[17:9], pixel_in[37:18]
   input  logic [1:0]                    req_tuser,   // action[1:0]
   // result output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [39:0]                   rsp_tdata,   // col_out[8:0], row_out[17:9], pixel_out[37:18]
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [h1rpu_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [h1rpu_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [h1rpu_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);

`include "h1_regularization_pixel_update_defines.svh"

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CW     = h1rpu_pkg::COORD_W;
   localparam int PW     = h1rpu_pkg::PIX_W;
   localparam int DW     = h1rpu_pkg::DIM_W;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD0  = 3'd1;
   localparam logic [2:0] S_RD1  = 3'd2;
   localparam logic [2:0] S_RD2  = 3'd3;
   localparam logic [2:0] S_LAP  = 3'd4;
   localparam logic [2:0] S_MUL  = 3'd5;
   localparam logic [2:0] S_WB   = 3'd6;

   // item kinds
   localparam logic [2:0] K_NONE = 3'd0;
   localparam logic [2:0] K_LOAD = 3'd1;
   localparam logic [2:0] K_READ = 3'd2;
   localparam logic [2:0] K_COPY = 3'd3;
   localparam logic [2:0] K_STEP = 3'd4;

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [CW-1:0] c,
                                                  input logic [CW-1:0] r);
      pix_addr = ADDR_W'(r * MAX_WIDTH + c);
   endfunction

   h1rpu_pkg::cfg_type      cfg;
   h1rpu_pkg::math_ctl_type mctl;

   logic [2:0]            state_ff, state_in;
   logic [2:0]            kind_ff, kind_in;
   logic [CW-1:0]         col_ff, row_ff, src_col_ff, src_row_ff;
   logic [CW-1:0]         src_col_in, src_row_in;
   logic signed [PW-1:0]  pix_ff;

   logic [CW-1:0]         in_col, in_row;
   logic [DW-1:0]         wd, hd, w_eff, h_eff, c13, r13;
   logic                  in_image, interior;
   logic                  accept, out_free;

   logic [PW-1:0]         cur_mem [0:DEPTH-1];
   logic [PW-1:0]         obs_mem [0:DEPTH-1];
   logic                  rd_en_a, rd_en_b, rd_en_obs;
   logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b, ctr_addr;
   logic signed [PW-1:0]  rd_a_ff, rd_b_ff, rd_obs_ff;
   logic                  cur_we, obs_we;
   logic signed [PW-1:0]  wb_value, step_result;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         rsp_col_ff, rsp_row_ff;
   logic signed [PW-1:0]  rsp_pix_ff;

   h1rpu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // image size in use, clamped to the supported range
   always_comb begin
      wd = DW'(cfg.image_width);
      hd = DW'(cfg.image_height);
      if (wd < DW'(h1rpu_pkg::MIN_DIM))  w_eff = DW'(h1rpu_pkg::MIN_DIM);
      else if (wd > DW'(MAX_WIDTH))      w_eff = DW'(MAX_WIDTH);
      else                               w_eff = wd;
      if (hd < DW'(h1rpu_pkg::MIN_DIM))  h_eff = DW'(h1rpu_pkg::MIN_DIM);
      else if (hd > DW'(MAX_HEIGHT))     h_eff = DW'(MAX_HEIGHT);
      else                               h_eff = hd;
   end

   // classify the incoming item
   assign in_col   = req_tdata[8:0];
   assign in_row   = req_tdata[17:9];
   assign c13      = DW'(in_col);
   assign r13      = DW'(in_row);
   assign in_image = (c13 < w_eff) && (r13 < h_eff);
   assign interior = (c13 != '0) && (c13 < w_eff - DW'(1))
                  && (r13 != '0) && (r13 < h_eff - DW'(1));

   always_comb begin
      if (!in_image)                          kind_in = K_NONE;
      else if (req_tuser == h1rpu_pkg::ACT_LOAD)   kind_in = K_LOAD;
      else if (req_tuser != h1rpu_pkg::ACT_UPDATE) kind_in = K_READ;
      else if (interior)                      kind_in = K_STEP;
      else                                    kind_in = K_COPY;
      // border source: the row rule wins at corners
      src_col_in = in_col;
      src_row_in = in_row;
      if (r13 == '0)                         src_row_in = CW'(1);
      else if (r13 == h_eff - DW'(1))        src_row_in = CW'(h_eff - DW'(2));
      else if (c13 == '0)                    src_col_in = CW'(1);
      else                                   src_col_in = CW'(w_eff - DW'(2));
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            state_in = (kind_in == K_NONE || kind_in == K_LOAD) ? S_WB : S_RD0;
         end
         S_RD0:  state_in = (kind_ff == K_STEP) ? S_RD1 : S_WB;
         S_RD1:  state_in = S_RD2;
         S_RD2:  state_in = S_LAP;
         S_LAP:  state_in = S_MUL;
         S_MUL:  state_in = S_WB;
         S_WB:   if (out_free) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= kind_in;
         col_ff     <= in_col;
         row_ff     <= in_row;
         pix_ff     <= $signed(req_tdata[37:18]);
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
      end
   end

   // read port schedule: center+east, west+south, north
   assign ctr_addr = pix_addr(col_ff, row_ff);

   always_comb begin
      rd_en_a   = 1'b0;
      rd_en_b   = 1'b0;
      rd_en_obs = 1'b0;
      rd_addr_a = ctr_addr;
      rd_addr_b = ctr_addr;
      unique case (state_ff)
         S_RD0: begin
            rd_en_a = 1'b1;
            if (kind_ff == K_COPY) begin
               rd_addr_a = pix_addr(src_col_ff, src_row_ff);
            end
            if (kind_ff == K_STEP) begin
               rd_en_b   = 1'b1;
               rd_en_obs = 1'b1;
               rd_addr_b = pix_addr(col_ff + CW'(1), row_ff);
            end
         end
         S_RD1: begin
            rd_en_a   = 1'b1;
            rd_en_b   = 1'b1;
            rd_addr_a = pix_addr(col_ff - CW'(1), row_ff);
            rd_addr_b = pix_addr(col_ff, row_ff + CW'(1));
         end
         S_RD2: begin
            rd_en_a   = 1'b1;
            rd_addr_a = pix_addr(col_ff, row_ff - CW'(1));
         end
         default: ;
      endcase
   end

   // write-back value and enables
   always_comb begin
      case (kind_ff)
         K_LOAD:  wb_value = pix_ff;
         K_READ:  wb_value = rd_a_ff;
         K_COPY:  wb_value = rd_a_ff;
         K_STEP:  wb_value = step_result;
         default: wb_value = '0;
      endcase
   end

   assign cur_we = (state_ff == S_WB) && out_free
                && (kind_ff == K_LOAD || kind_ff == K_COPY || kind_ff == K_STEP);
   assign obs_we = (state_ff == S_WB) && out_free && (kind_ff == K_LOAD);

   // current estimate memory: one write, two reads
   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[ctr_addr] <= wb_value;
      end
      if (rd_en_a) begin
         rd_a_ff <= cur_mem[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= cur_mem[rd_addr_b];
      end
   end

   // observed image memory
   always_ff @(posedge clock) begin
      if (obs_we) begin
         obs_mem[ctr_addr] <= pix_ff;
      end
      if (rd_en_obs) begin
         rd_obs_ff <= obs_mem[ctr_addr];
      end
   end

   // arithmetic phases follow the read schedule
   always_comb begin
      mctl.load_center = (state_ff == S_RD1);
      mctl.add_pair    = (state_ff == S_RD2);
      mctl.add_last    = (state_ff == S_LAP);
      mctl.mult        = (state_ff == S_MUL);
   end

   h1rpu_math u_math (
      .clock          (clock),
      .ctl            (mctl),
      .fidelity_step  (cfg.fidelity_step),
      .smoothing_step (cfg.smoothing_step),
      .port_a         (rd_a_ff),
      .port_b         (rd_b_ff),
      .observed       (rd_obs_ff),
      .step_result    (step_result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_WB && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WB && out_free) begin
         rsp_col_ff <= col_ff;
         rsp_row_ff <= row_ff;
         rsp_pix_ff <= wb_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_pix_ff, rsp_row_ff, rsp_col_ff};

   // checks
   `H1RPU_ASSERT_NOW(a_write_only_in_wb, clock, reset, cur_we,
      (state_ff == S_WB) && out_free, "estimate written outside write-back")
   `H1RPU_ASSERT_NOW(a_obs_with_cur, clock, reset, obs_we,
      cur_we, "observed write without estimate write")
   `H1RPU_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept,
      state_ff != S_IDLE, "sequencer stayed idle after accept")
   `H1RPU_ASSERT_NEXT(a_wb_gives_result, clock, reset, (state_ff == S_WB) && out_free,
      rsp_valid_ff && (state_ff == S_IDLE), "write-back did not post a result")

endmodule

### test/testbench.sv
// Self-checking testbench of the H1 pixel update block: directed and random items, scored per field.
`timescale 1ns / 100ps

module testbench;

   localparam int IMG_SIDE     = 512;
   localparam int IMG_PIXELS   = IMG_SIDE * IMG_SIDE;
   localparam int PIX_MAX      = 524287;
   localparam int PIX_MIN      = -524288;
   localparam int SMALL_SIDE   = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 12;
   localparam int QUIET_LIMIT  = 4000;
   // action 3 is decoded as a read
   localparam logic [h1rpu_pkg::ACTION_W-1:0] ACT_READ_ALT = 2'd3;

   typedef struct {
      logic [h1rpu_pkg::ACTION_W-1:0]     action;
      logic [h1rpu_pkg::COORD_W-1:0]      col;
      logic [h1rpu_pkg::COORD_W-1:0]      row;
      logic signed [h1rpu_pkg::PIX_W-1:0] pixel;
   } pixel_item_type;

   typedef struct {
      logic [h1rpu_pkg::COORD_W-1:0]      col;
      logic [h1rpu_pkg::COORD_W-1:0]      row;
      logic signed [h1rpu_pkg::PIX_W-1:0] pixel;
   } pixel_report_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [39:0]                  req_tdata   = '0;  // col[8:0], row[17:9], pixel_in[37:18]
   logic [1:0]                   req_tuser   = '0;  // action[1:0]
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [39:0]                  rsp_tdata;         // col_out[8:0], row_out[17:9], pixel_out[37:18]
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [h1rpu_pkg::CSR_AW-1:0] csr_paddr   = '0;
   logic [h1rpu_pkg::CSR_DW-1:0] csr_pwdata  = '0;
   logic [h1rpu_pkg::CSR_DW-1:0] csr_prdata;
   logic                         csr_pready;

   h1_regularization_pixel_update dut (.*);

   always #10 clock = ~clock;

   // image copies, register copies and the results still owed by the block
   logic signed [h1rpu_pkg::PIX_W-1:0] current_px  [0:IMG_PIXELS-1];
   logic signed [h1rpu_pkg::PIX_W-1:0] observed_px [0:IMG_PIXELS-1];
   bit                      pixel_loaded [0:IMG_PIXELS-1];
   int                      fid_step    = int'(h1rpu_pkg::FIDELITY_RST);
   int                      smooth_step = int'(h1rpu_pkg::SMOOTHING_RST);
   int                      width_cfg   = int'(h1rpu_pkg::WIDTH_RST);
   int                      height_cfg  = int'(h1rpu_pkg::HEIGHT_RST);
   pixel_report_type        pending_pixels [$];

   int fail_count    = 0;
   int send_gap_pct  = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   function automatic int unsigned pix_index(int unsigned c, int unsigned r);
      return r * IMG_SIDE + c;
   endfunction

   function automatic int unsigned clamp_side(int unsigned v);
      if (v < h1rpu_pkg::MIN_DIM) return h1rpu_pkg::MIN_DIM;
      if (v > IMG_SIDE) return IMG_SIDE;
      return v;
   endfunction

   // pixel and every in-image 4-neighbor written at least once
   function automatic bit stencil_ready(int unsigned c, int unsigned r,
                                        int unsigned w, int unsigned h);
      return pixel_loaded[pix_index(c, r)]
         && (c == 0 || pixel_loaded[pix_index(c - 1, r)])
         && (c + 1 >= w || pixel_loaded[pix_index(c + 1, r)])
         && (r == 0 || pixel_loaded[pix_index(c, r - 1)])
         && (r + 1 >= h || pixel_loaded[pix_index(c, r + 1)]);
   endfunction

   // expected result of one item; updates the image copies
   function automatic pixel_report_type apply_pixel_action(pixel_item_type it);
      int unsigned      c, r, w, h, idx;
      longint           u, diff, lap, total, stepped;
      pixel_report_type res;
      c = it.col;
      r = it.row;
      w = clamp_side(width_cfg);
      h = clamp_side(height_cfg);
      res.col   = it.col;
      res.row   = it.row;
      res.pixel = '0;
      if (c < w && r < h) begin
         idx = pix_index(c, r);
         if (it.action == h1rpu_pkg::ACT_LOAD) begin
            observed_px[idx]  = it.pixel;
            current_px[idx]   = it.pixel;
            pixel_loaded[idx] = 1'b1;
         end else if (it.action == h1rpu_pkg::ACT_UPDATE) begin
            if (c > 0 && c < w - 1 && r > 0 && r < h - 1) begin
               // explicit step: data term plus five-point Laplacian, Q.24 rounded to Q.8
               u    = current_px[idx];
               diff = longint'(observed_px[idx]) - u;
               lap  = longint'(current_px[pix_index(c + 1, r)])
                    + longint'(current_px[pix_index(c - 1, r)])
                    + longint'(current_px[pix_index(c, r + 1)])
                    + longint'(current_px[pix_index(c, r - 1)]) - 4 * u;
               total   = fid_step * diff + smooth_step * lap;
               stepped = u + ((total + 64'sd32768) >>> 16);
               if (stepped > PIX_MAX) stepped = PIX_MAX;
               if (stepped < PIX_MIN) stepped = PIX_MIN;
               current_px[idx] = h1rpu_pkg::PIX_W'(stepped);
            end else begin
               // Neumann border: column copy first, then row copy wins at corners
               if (c == 0) current_px[idx] = current_px[pix_index(1, r)];
               else if (c == w - 1) current_px[idx] = current_px[pix_index(w - 2, r)];
               if (r == 0) current_px[idx] = current_px[pix_index(c, 1)];
               else if (r == h - 1) current_px[idx] = current_px[pix_index(c, h - 2)];
            end
         end
         res.pixel = current_px[idx];
      end
      return res;
   endfunction

   function automatic logic signed [h1rpu_pkg::PIX_W-1:0] pick_pixel();
      case ($urandom_range(7))
         0: return h1rpu_pkg::PIX_W'(PIX_MAX);
         1: return h1rpu_pkg::PIX_W'(PIX_MIN);
         default: return h1rpu_pkg::PIX_W'($urandom);
      endcase
   endfunction

   // small images anywhere, large ones near their edges
   function automatic int unsigned pick_coord(int unsigned side);
      if (side <= SMALL_SIDE) return $urandom_range(side - 1);
      if ($urandom_range(1)) return $urandom_range(4);
      return side - 1 - $urandom_range(4);
   endfunction

   function automatic pixel_item_type pick_item();
      pixel_item_type it;
      int unsigned    roll, w, h;
      bit             ready;
      w        = clamp_side(width_cfg);
      h        = clamp_side(height_cfg);
      roll     = $urandom_range(99);
      it.pixel = pick_pixel();
      it.col   = h1rpu_pkg::COORD_W'(pick_coord(w));
      it.row   = h1rpu_pkg::COORD_W'(pick_coord(h));
      if (roll < 45) it.action = h1rpu_pkg::ACT_UPDATE;
      else if (roll < 65) it.action = h1rpu_pkg::ACT_READ;
      else if (roll < 85) it.action = h1rpu_pkg::ACT_LOAD;
      else begin
         // noise: any code, any coordinate
         it.action = h1rpu_pkg::ACTION_W'($urandom_range(3));
         it.col    = h1rpu_pkg::COORD_W'($urandom_range(511));
         it.row    = h1rpu_pkg::COORD_W'($urandom_range(511));
      end
      // never touch memory that was not written yet: load it instead
      if (it.col < w && it.row < h && it.action != h1rpu_pkg::ACT_LOAD) begin
         if (it.action == h1rpu_pkg::ACT_UPDATE) ready = stencil_ready(it.col, it.row, w, h);
         else ready = pixel_loaded[pix_index(it.col, it.row)];
         if (!ready) it.action = h1rpu_pkg::ACT_LOAD;
      end
      return it;
   endfunction

   // offer one item, with random gaps, until it is taken
   task automatic send_item(input pixel_item_type it);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {2'b00, it.pixel, it.row, it.col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_pixels.push_back(apply_pixel_action(it));
      @(negedge clock);
   endtask

   task automatic issue(input logic [h1rpu_pkg::ACTION_W-1:0] action, input int unsigned c,
                        input int unsigned r, input int pix);
      pixel_item_type it;
      it.action = action;
      it.col    = h1rpu_pkg::COORD_W'(c);
      it.row    = h1rpu_pkg::COORD_W'(r);
      it.pixel  = h1rpu_pkg::PIX_W'(pix);
      send_item(it);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // one register access: setup cycle, access cycle, then the bus returns to idle
   task automatic csr_access(input bit write, input logic [1:0] index,
                             input logic [h1rpu_pkg::CSR_DW-1:0] wdata,
                             output logic [h1rpu_pkg::CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= h1rpu_pkg::CSR_AW'({index, 2'b00});
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input int unsigned value);
      logic [h1rpu_pkg::CSR_DW-1:0] unused;
      csr_access(1'b1, index, value, unused);
      case (index)
         h1rpu_pkg::REG_FIDELITY:  fid_step    = value & 32'hFFFF;
         h1rpu_pkg::REG_SMOOTHING: smooth_step = value & 32'hFFFF;
         h1rpu_pkg::REG_WIDTH:     width_cfg   = value & 32'h3FF;
         h1rpu_pkg::REG_HEIGHT:    height_cfg  = value & 32'h3FF;
         default: ;
      endcase
   endtask

   task automatic check_reg(input logic [1:0] index, input int unsigned want);
      logic [h1rpu_pkg::CSR_DW-1:0] got;
      csr_access(1'b0, index, '0, got);
      if (got !== want) begin
         $display("%0t: register %0d readback, expected %0d, got %0d",
                  $time, index, want, got);
         fail_count++;
      end
   endtask

   task automatic configure(input int unsigned fid, input int unsigned smo,
                            input int unsigned w, input int unsigned h);
      wait_idle();
      write_reg(h1rpu_pkg::REG_FIDELITY, fid);
      write_reg(h1rpu_pkg::REG_SMOOTHING, smo);
      write_reg(h1rpu_pkg::REG_WIDTH, w);
      write_reg(h1rpu_pkg::REG_HEIGHT, h);
      check_reg(h1rpu_pkg::REG_FIDELITY, fid_step);
      check_reg(h1rpu_pkg::REG_SMOOTHING, smooth_step);
      check_reg(h1rpu_pkg::REG_WIDTH, width_cfg);
      check_reg(h1rpu_pkg::REG_HEIGHT, height_cfg);
   endtask

   // one setting: optional long receiver hold, preload of small images, random items
   task automatic run_phase(input int gap_pct, input int stall, input int unsigned fid,
                            input int unsigned smo, input int unsigned w,
                            input int unsigned h, input int count, input bit hold);
      int unsigned cw, ch;
      configure(fid, smo, w, h);
      send_gap_pct = gap_pct;
      stall_pct    = stall;
      cw = clamp_side(width_cfg);
      ch = clamp_side(height_cfg);
      if (hold) begin
         @(posedge clock);
         hold_requests++;
         @(negedge clock);
      end
      if (cw <= SMALL_SIDE && ch <= SMALL_SIDE)
         for (int r = 0; r < ch; r++)
            for (int c = 0; c < cw; c++)
               issue(h1rpu_pkg::ACT_LOAD, c, r, pick_pixel());
      repeat (count) send_item(pick_item());
   endtask

   task automatic test_register_reset();
      check_reg(h1rpu_pkg::REG_FIDELITY, 32'(h1rpu_pkg::FIDELITY_RST));
      check_reg(h1rpu_pkg::REG_SMOOTHING, 32'(h1rpu_pkg::SMOOTHING_RST));
      check_reg(h1rpu_pkg::REG_WIDTH, 32'(h1rpu_pkg::WIDTH_RST));
      check_reg(h1rpu_pkg::REG_HEIGHT, 32'(h1rpu_pkg::HEIGHT_RST));
   endtask

   // full-size image: extreme values, extreme coordinates, corner copies, both read codes
   task automatic test_extremes();
      issue(h1rpu_pkg::ACT_LOAD, 0, 0, PIX_MAX);
      issue(h1rpu_pkg::ACT_LOAD, 1, 0, PIX_MIN);
      issue(h1rpu_pkg::ACT_LOAD, 0, 1, -1);
      issue(h1rpu_pkg::ACT_LOAD, 511, 511, PIX_MIN);
      issue(h1rpu_pkg::ACT_LOAD, 510, 511, PIX_MAX);
      issue(h1rpu_pkg::ACT_LOAD, 511, 510, 12345);
      issue(h1rpu_pkg::ACT_UPDATE, 0, 0, 0);
      issue(h1rpu_pkg::ACT_UPDATE, 511, 511, 0);
      issue(h1rpu_pkg::ACT_READ, 511, 511, 0);
      issue(ACT_READ_ALT, 0, 0, 0);
   endtask

   // 3x3 image, maximum steps: saturation, border copies, coordinates outside
   task automatic test_small_image();
      configure(16'hFFFF, 16'hFFFF, 3, 3);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            issue(h1rpu_pkg::ACT_LOAD, c, r, (c == 1 && r == 1) ? PIX_MIN :
                                  ((c == 1 || r == 1) ? PIX_MAX : 0));
      issue(h1rpu_pkg::ACT_UPDATE, 1, 1, 0);
      issue(h1rpu_pkg::ACT_UPDATE, 2, 1, 0);
      issue(h1rpu_pkg::ACT_UPDATE, 1, 2, 0);
      issue(h1rpu_pkg::ACT_UPDATE, 3, 1, 0);
      issue(h1rpu_pkg::ACT_READ, 1, 511, 0);
      issue(h1rpu_pkg::ACT_LOAD, 511, 0, PIX_MAX);
      issue(ACT_READ_ALT, 511, 511, 0);
      issue(ACT_READ_ALT, 2, 1, 0);
   endtask

   task automatic test_random_sweep();
      run_phase(0, 0, h1rpu_pkg::FIDELITY_RST, h1rpu_pkg::SMOOTHING_RST, 5, 4, 40, 1'b0);
      run_phase(49, 0, 16'hFFFF, 16'hFFFF, 3, 3, 30, 1'b0);
      run_phase(0, 49, 0, 0, 0, 1023, 35, 1'b0);
      run_phase(9, 9, $urandom_range(65535), $urandom_range(65535), 1023, 2, 35, 1'b0);
      run_phase(0, 0, $urandom_range(65535), $urandom_range(65535), 512, 512, 30, 1'b0);
      run_phase(49, 0, $urandom_range(65535), $urandom_range(65535), 8, 7, 25, 1'b0);
      run_phase(0, 49, $urandom_range(65535), 1, 100, 6, 30, 1'b0);
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      run_phase(0, 0, $urandom_range(65535), $urandom_range(65535), 6, 5, 30, 1'b1);
   endtask

   // receiver: random stalls, plus a long hold when one is requested
   always @(negedge clock) begin
      if (hold_taken != hold_requests) begin
         hold_taken = hold_requests;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic flag_mismatch(input string what, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fail_count++;
   endtask

   // score each result item against the oldest expectation
   always @(posedge clock) begin : score_results
      pixel_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result item, expected none, got %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[8:0] !== want.col)
               flag_mismatch("col_out", int'(want.col), int'(rsp_tdata[8:0]));
            if (rsp_tdata[17:9] !== want.row)
               flag_mismatch("row_out", int'(want.row), int'(rsp_tdata[17:9]));
            if (rsp_tdata[37:18] !== want.pixel)
               flag_mismatch("pixel_out", int'(want.pixel), int'($signed(rsp_tdata[37:18])));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_register_reset();
      test_extremes();
      test_small_image();
      test_random_sweep();
      test_backpressure();
      wait_idle();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_pixels.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
